### rtl/smle_pkg.sv
// Shared constants, types and the exponent-table generator for the stereo mu-law expander.
`default_nettype none
package smle_pkg;

    localparam int SAMPLE_BITS_DEF       = 24;
    localparam int EXP_TABLE_ENTRIES_DEF = 256;
    localparam int NUM_LANES             = 2;
    localparam int LANE_STAGES           = 11;
    localparam int GAIN_BITS             = 17;
    localparam int CFG_IDX_BITS          = 1;
    localparam int M_BITS                = 41;
    localparam int REM_BITS              = 11;

    localparam logic [GAIN_BITS-1:0] UNIT_Q16 = GAIN_BITS'(65536);
    localparam logic [63:0]          LN2_Q30  = 64'd744261118;
    localparam logic [63:0]          Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0]          Q30_TWO  = 64'd1 << 31;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INPUT_GAIN = 1'b0,
        CFG_WET_MIX    = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [LANE_STAGES-1:0] lane_load;
        logic                   out_load;
    } t_pipe_ctrl;

    // 2^u in Q1.30 for u in Q0.30, exp series truncated after the twentieth power
    function automatic logic [63:0] exp_q30(input logic [63:0] u);
        logic [63:0] v;
        logic [63:0] term;
        logic [63:0] sum;
        v    = (u * LN2_Q30) >> 30;
        sum  = Q30_ONE;
        term = Q30_ONE;
        term = ((term * v) >> 30) / 64'd1;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd2;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd3;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd4;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd5;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd6;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd7;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd8;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd9;  sum = sum + term;
        term = ((term * v) >> 30) / 64'd10; sum = sum + term;
        term = ((term * v) >> 30) / 64'd11; sum = sum + term;
        term = ((term * v) >> 30) / 64'd12; sum = sum + term;
        term = ((term * v) >> 30) / 64'd13; sum = sum + term;
        term = ((term * v) >> 30) / 64'd14; sum = sum + term;
        term = ((term * v) >> 30) / 64'd15; sum = sum + term;
        term = ((term * v) >> 30) / 64'd16; sum = sum + term;
        term = ((term * v) >> 30) / 64'd17; sum = sum + term;
        term = ((term * v) >> 30) / 64'd18; sum = sum + term;
        term = ((term * v) >> 30) / 64'd19; sum = sum + term;
        term = ((term * v) >> 30) / 64'd20; sum = sum + term;
        return sum;
    endfunction

endpackage
`default_nettype wire

### rtl/smle_ctrl.sv
// Valid tracking and per-stage load enables for the lane pipeline and output register.
`default_nettype none
module smle_ctrl
    import smle_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output t_pipe_ctrl      o_ctrl
);

    logic [LANE_STAGES:0] r_vld;
    logic [LANE_STAGES:0] w_load;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_load[LANE_STAGES] = !r_vld[LANE_STAGES] || i_out_ready;
        for (int k = LANE_STAGES - 1; k >= 0; k--) begin
            w_load[k] = !r_vld[k] || w_load[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k <= LANE_STAGES; k++) begin
                if (w_load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready       = w_load[0];
    assign o_out_valid      = r_vld[LANE_STAGES];
    assign o_ctrl.lane_load = w_load[LANE_STAGES-1:0];
    assign o_ctrl.out_load  = w_load[LANE_STAGES];

endmodule
`default_nettype wire

### rtl/smle_lane.sv
// One channel of the expander: gain, clamp, table exponent, divide by 255, mix products.
`default_nettype none
module smle_lane
    import smle_pkg::*;
#(
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire t_pipe_ctrl                    i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [GAIN_BITS-1:0]          i_input_gain,
    input  wire logic [GAIN_BITS-1:0]          i_wet_mix,
    output logic signed [SAMPLE_BITS+17:0]     o_wet_prod,
    output logic signed [SAMPLE_BITS+17:0]     o_dry_prod
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = SAMPLE_BITS - 4;
    localparam int IDXW = $clog2(EXP_TABLE_ENTRIES);
    localparam int PW   = F + IDXW;
    localparam int SH   = 30 - F;
    localparam logic [S+1:0]      ONE_G    = (S+2)'(1) << F;
    localparam logic [M_BITS-1:0] Q30_M    = M_BITS'(Q30_ONE);
    localparam logic [M_BITS-1:0] HALF_DEN = M_BITS'((255 << SH) >> 1);

    // constant exponent table, split into lower and upper interpolation points
    logic [31:0] w_lo_tab [EXP_TABLE_ENTRIES];
    logic [31:0] w_hi_tab [EXP_TABLE_ENTRIES];

    for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_tab
        localparam logic [63:0] U_LO = (64'(k) << 30) / EXP_TABLE_ENTRIES;
        localparam logic [63:0] U_HI = (64'(k + 1) << 30) / EXP_TABLE_ENTRIES;
        localparam logic [63:0] E_LO = (k == 0) ? Q30_ONE : exp_q30(U_LO);
        localparam logic [63:0] E_HI = (k + 1 == EXP_TABLE_ENTRIES) ? Q30_TWO : exp_q30(U_HI);
        assign w_lo_tab[k] = E_LO[31:0];
        assign w_hi_tab[k] = E_HI[31:0];
    end

    // dry sample, sign and integer shift travel beside the datapath
    logic signed [S-1:0] r_dry [10];
    logic                r_neg [9];
    logic [3:0]          r_n   [4];

    logic [S+16:0]       r_gprod;
    logic [F:0]          r_g;
    logic [PW-1:0]       r_pos;
    logic [31:0]         r_lo4;
    logic [31:0]         r_diff;
    logic [F-1:0]        r_rem;
    logic [31:0]         r_lo5;
    logic [F+31:0]       r_ip;
    logic [31:0]         r_p;
    logic [M_BITS-1:0]   r_m7;
    logic [M_BITS-1:0]   r_m8;
    logic [M_BITS-1:0]   r_s8;
    logic [F:0]          r_s9;
    logic [REM_BITS-1:0] r_r9;
    logic signed [S-1:0] r_y;
    logic signed [S+17:0] r_wet_prod;
    logic signed [S+17:0] r_dry_prod;

    logic [S-1:0]         n_mag;
    logic [S+16:0]        n_gprod;
    logic [S+17:0]        w_gsum;
    logic [F:0]           n_g;
    logic [PW-1:0]        n_pos;
    logic [IDXW-1:0]      w_idx;
    logic [31:0]          w_hi;
    logic [31:0]          n_lo4;
    logic [31:0]          n_diff;
    logic [F+31:0]        n_ip;
    logic [31:0]          n_p;
    logic [M_BITS-1:0]    w_pow;
    logic [M_BITS-1:0]    n_m7;
    logic [M_BITS-1:0]    n_s8;
    logic [M_BITS-1:0]    w_rfull;
    logic [REM_BITS:0]    w_r1;
    logic [REM_BITS:0]    w_rsum;
    logic [S-1:0]         w_q;
    logic signed [S-1:0]  n_y;
    logic [GAIN_BITS-1:0] w_dry_w;
    logic signed [S+17:0] n_wet_prod;
    logic signed [S+17:0] n_dry_prod;

    always_comb begin
        // stage 1: magnitude times gain
        n_mag   = i_sample[S-1] ? S'(-i_sample) : S'(i_sample);
        n_gprod = (S+17)'(n_mag) * (S+17)'(i_input_gain);

        // stage 2: round and clamp to 1.0
        w_gsum = (S+18)'(r_gprod) + (S+18)'(32768);
        n_g    = (w_gsum[S+17:16] > ONE_G) ? ONE_G[F:0] : w_gsum[F+16:16];

        // stage 3: fractional part of 8|x| scaled to table positions
        n_pos = PW'({r_g[F-4:0], 3'b000}) * PW'(EXP_TABLE_ENTRIES);

        // stage 4: table read
        w_idx  = r_pos[PW-1:F];
        n_lo4  = w_lo_tab[w_idx];
        w_hi   = w_hi_tab[w_idx];
        n_diff = w_hi - n_lo4;

        // stage 5: interpolation product
        n_ip = (F+32)'(r_diff) * (F+32)'(r_rem);

        // stage 6: interpolated 2^f
        n_p = r_lo5 + r_ip[F+31:F];

        // stage 7: integer shift, minus one, rounding offset, drop to sample scale
        w_pow = M_BITS'(r_p) << r_n[3];
        n_m7  = (w_pow - Q30_M + HALF_DEN) >> SH;

        // stage 8: quotient estimate by 255 from a geometric sum of shifts
        n_s8 = (r_m7 >> 8) + (r_m7 >> 16) + (r_m7 >> 24) + (r_m7 >> 32) + (r_m7 >> 40);

        // stage 9: remainder of the estimate, known to stay below 2048
        w_rfull = r_m8 - ((r_s8 << 8) - r_s8);

        // stage 10: finish the small remainder division and restore the sign
        w_r1   = (REM_BITS+1)'(r_r9) + (REM_BITS+1)'(1);
        w_rsum = w_r1 + (w_r1 >> 8);
        w_q    = S'(r_s9) + S'(w_rsum[REM_BITS:8]);
        n_y    = r_neg[8] ? $signed(S'(-w_q)) : $signed(w_q);

        // stage 11: wet and dry products
        w_dry_w    = UNIT_Q16 - i_wet_mix;
        n_wet_prod = (S+18)'(r_y) * (S+18)'($signed({1'b0, i_wet_mix}));
        n_dry_prod = (S+18)'(r_dry[9]) * (S+18)'($signed({1'b0, w_dry_w}));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.lane_load[0]) begin
            r_dry[0] <= i_sample;
            r_neg[0] <= i_sample[S-1];
            r_gprod  <= n_gprod;
        end
        if (i_ctrl.lane_load[1]) begin
            r_g <= n_g;
        end
        if (i_ctrl.lane_load[2]) begin
            r_pos  <= n_pos;
            r_n[0] <= r_g[F:F-3];
        end
        if (i_ctrl.lane_load[3]) begin
            r_lo4  <= n_lo4;
            r_diff <= n_diff;
            r_rem  <= r_pos[F-1:0];
        end
        if (i_ctrl.lane_load[4]) begin
            r_lo5 <= r_lo4;
            r_ip  <= n_ip;
        end
        if (i_ctrl.lane_load[5]) begin
            r_p <= n_p;
        end
        if (i_ctrl.lane_load[6]) begin
            r_m7 <= n_m7;
        end
        if (i_ctrl.lane_load[7]) begin
            r_m8 <= r_m7;
            r_s8 <= n_s8;
        end
        if (i_ctrl.lane_load[8]) begin
            r_s9 <= r_s8[F:0];
            r_r9 <= w_rfull[REM_BITS-1:0];
        end
        if (i_ctrl.lane_load[9]) begin
            r_y <= n_y;
        end
        if (i_ctrl.lane_load[10]) begin
            r_wet_prod <= n_wet_prod;
            r_dry_prod <= n_dry_prod;
        end
        // side registers follow their stage
        for (int k = 1; k < 10; k++) begin
            if (i_ctrl.lane_load[k]) begin
                r_dry[k] <= r_dry[k-1];
            end
        end
        for (int k = 1; k < 9; k++) begin
            if (i_ctrl.lane_load[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
        for (int k = 1; k < 4; k++) begin
            if (i_ctrl.lane_load[k+2]) begin
                r_n[k] <= r_n[k-1];
            end
        end
    end

    assign o_wet_prod = r_wet_prod;
    assign o_dry_prod = r_dry_prod;

endmodule
`default_nettype wire

### rtl/smle_merge.sv
// Output stage: sum wet and dry products per lane, round, saturate, pack the stereo frame.
`default_nettype none
module smle_merge
    import smle_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TDATA_BITS  = ((NUM_LANES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire t_pipe_ctrl                    i_ctrl,
    input  wire logic signed [SAMPLE_BITS+17:0] i_wet_prod [NUM_LANES],
    input  wire logic signed [SAMPLE_BITS+17:0] i_dry_prod [NUM_LANES],
    output logic [TDATA_BITS-1:0]              o_tdata
);

    localparam int S = SAMPLE_BITS;
    localparam logic signed [S+2:0] SAT_MAX = (S+3)'((64'sd1 <<< (S - 1)) - 64'sd1);
    localparam logic signed [S+2:0] SAT_MIN = -SAT_MAX - (S+3)'(1);

    logic signed [S+18:0]  w_sum [NUM_LANES];
    logic signed [S+2:0]   w_rnd [NUM_LANES];
    logic [TDATA_BITS-1:0] n_tdata;
    logic [TDATA_BITS-1:0] r_tdata;

    always_comb begin
        n_tdata = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            w_sum[l] = (S+19)'(i_wet_prod[l]) + (S+19)'(i_dry_prod[l]) + (S+19)'(32768);
            w_rnd[l] = w_sum[l][S+18:16];
            if (w_rnd[l] > SAT_MAX) begin
                n_tdata[l*S +: S] = SAT_MAX[S-1:0];
            end else if (w_rnd[l] < SAT_MIN) begin
                n_tdata[l*S +: S] = SAT_MIN[S-1:0];
            end else begin
                n_tdata[l*S +: S] = w_rnd[l][S-1:0];
            end
        end
    end

    // hold the frame while the downstream side stalls
    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_tdata <= n_tdata;
        end
    end

    assign o_tdata = r_tdata;

endmodule
`default_nettype wire

### rtl/stereo_mu_law_expander.sv
// Stereo mu-law expander: two channel lanes in lockstep, one frame per cycle unless the output stalls.
// Path: a frame accepted on s_axis passes 11 lane stages plus the output register before it
//   appears on m_axis.
// Throughput: one stereo frame per clock unless the output stalls; a stalled output lets empty stages fill behind it.
// Reset (i_rst_n low, synchronous): drops every frame in flight and sets input_gain and
//   wet_mix back to unity.
`default_nettype none
module stereo_mu_law_expander
    import smle_pkg::*;
#(
    parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF,
    parameter int TDATA_BITS        = ((NUM_LANES * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [GAIN_BITS-1:0]    i_cfg_wdata,
    // input frames
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [TDATA_BITS-1:0]   s_axis_tdata,  // sample_left, sample_right, zero pad
    // output frames
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [TDATA_BITS-1:0]        m_axis_tdata   // result_left, result_right, zero pad
);

    logic [GAIN_BITS-1:0] r_input_gain;
    logic [GAIN_BITS-1:0] r_wet_mix;
    logic [GAIN_BITS-1:0] w_cfg_value;
    t_pipe_ctrl           w_ctrl;

    logic signed [SAMPLE_BITS+17:0] w_wet_prod [NUM_LANES];
    logic signed [SAMPLE_BITS+17:0] w_dry_prod [NUM_LANES];

    // clip register writes above unity gain
    assign w_cfg_value = (i_cfg_wdata > UNIT_Q16) ? UNIT_Q16 : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain <= UNIT_Q16;
            r_wet_mix    <= UNIT_Q16;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_INPUT_GAIN: begin
                    r_input_gain <= w_cfg_value;
                end
                CFG_WET_MIX: begin
                    r_wet_mix <= w_cfg_value;
                end
                default: begin
                    r_input_gain <= r_input_gain;
                end
            endcase
        end
    end

    // shared stage control: every lane advances on the same enables
    smle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ctrl      (w_ctrl)
    );

    // one lane per channel; lane l takes its sample from slot l of tdata
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        smle_lane #(
            .SAMPLE_BITS       (SAMPLE_BITS),
            .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
        ) u_lane (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_sample     (s_axis_tdata[l*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_input_gain (r_input_gain),
            .i_wet_mix    (r_wet_mix),
            .o_wet_prod   (w_wet_prod[l]),
            .o_dry_prod   (w_dry_prod[l])
        );
    end

    // final mix, saturation and output register
    smle_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TDATA_BITS  (TDATA_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_wet_prod (w_wet_prod),
        .i_dry_prod (w_dry_prod),
        .o_tdata    (m_axis_tdata)
    );

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_mu_law_expander: directed and random frames vs. a local model.
module tb;
    import smle_pkg::*;

    localparam int SW             = 24;        // sample width
    localparam int FRAC           = SW - 4;    // fractional bits of Q4.20
    localparam int TAB_N          = 256;       // interpolation segments of 2^f
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 24;        // wait for stray results after the drain
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQS     = 110;
    localparam int CALM_REQS      = 140;

    localparam logic signed [SW-1:0] ONE_Q20 = SW'(1 << FRAC);
    localparam logic signed [SW-1:0] MAX_S   = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_S   = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [SW-1:0] right;
        logic [SW-1:0] left;
    } t_frame;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx     = CFG_INPUT_GAIN;
    logic [GAIN_BITS-1:0]    i_cfg_wdata   = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [2*SW-1:0]         s_axis_tdata  = '0;   // sample_left, sample_right
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [2*SW-1:0]         m_axis_tdata;         // result_left, result_right

    stereo_mu_law_expander dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Local model state: register copies, 2^f table, pending results
    // ------------------------------------------------------------------
    logic [GAIN_BITS-1:0] gain_q16 = UNIT_Q16;
    logic [GAIN_BITS-1:0] mix_q16  = UNIT_Q16;
    logic [63:0]          pow2_frac [0:TAB_N];
    t_frame               pending_results [$];
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;
    bit                   idle_on        = 1'b0;

    // Fill the Q1.30 table of 2^(k/TAB_N) with a truncated exp series;
    // pin both end points to exact powers of two.
    function automatic void build_pow2_table();
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k <= TAB_N; k++) begin
            u    = (64'(k) << 30) / TAB_N;
            v    = (u * LN2_Q30) >> 30;
            sum  = Q30_ONE;
            term = Q30_ONE;
            for (int i = 1; i <= 20; i++) begin
                term = ((term * v) >> 30) / 64'(i);
                sum  = sum + term;
            end
            pow2_frac[k] = sum;
        end
        pow2_frac[0]     = Q30_ONE;
        pow2_frac[TAB_N] = Q30_TWO;
    endfunction

    // One channel: gain, clamp to 1.0, expand (256^|x|-1)/255, blend with dry, saturate.
    function automatic logic [SW-1:0] expand_channel(input logic [SW-1:0] raw);
        longint          dry;
        longint unsigned mag, g, t, n, f, pos, idx, rem, lo, hi, p, num, den, ymag;
        longint          y, s, r;
        dry  = $signed(raw);
        mag  = (dry < 0) ? longint'(-dry) : longint'(dry);
        g    = (mag * longint'(gain_q16) + 64'd32768) >> 16;
        if (g > (64'd1 << FRAC)) g = 64'd1 << FRAC;
        // split 8*|x| into an integer shift and a fraction for the table
        t    = g << 3;
        n    = t >> FRAC;
        f    = t & ((64'd1 << FRAC) - 1);
        pos  = f * TAB_N;
        idx  = pos >> FRAC;
        rem  = pos & ((64'd1 << FRAC) - 1);
        if (idx > TAB_N - 1) idx = TAB_N - 1;
        if (n > 8) n = 8;
        lo   = pow2_frac[idx];
        hi   = pow2_frac[idx + 1];
        p    = lo + (((hi - lo) * rem) >> FRAC);
        num  = (p << n) - Q30_ONE;
        den  = 64'd255 << (30 - FRAC);
        ymag = (num + (den >> 1)) / den;
        y    = (dry < 0) ? -longint'(ymag) : longint'(ymag);
        s    = y * longint'(mix_q16) + dry * (longint'(UNIT_Q16) - longint'(mix_q16));
        r    = (s + 64'sd32768) >>> 16;   // floor after the half-step: ties toward +inf
        if (r > longint'(MAX_S)) r = MAX_S;
        if (r < longint'(MIN_S)) r = MIN_S;
        return r[SW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Reset once, then hold it released for the rest of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Hard stop in case the pipeline hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("[stereo_mu_law_expander] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side: stall in random bursts while idle_on is set
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left    = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each delivered result with the oldest pending expectation
    always @(posedge i_clk) begin
        t_frame exp_frame;
        t_frame got_frame;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_frame = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata=%h", m_axis_tdata);
                mismatch_count = mismatch_count + 1;
            end else begin
                exp_frame = pending_results.pop_front();
                if (got_frame.left !== exp_frame.left) begin
                    $error("result_left: expected %0d, actual %0d",
                           $signed(exp_frame.left), $signed(got_frame.left));
                    mismatch_count = mismatch_count + 1;
                end
                if (got_frame.right !== exp_frame.right) begin
                    $error("result_right: expected %0d, actual %0d",
                           $signed(exp_frame.right), $signed(got_frame.right));
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side. Called and returning at a falling edge. Hold tvalid high
    // across back-to-back requests; drop it only for an idle burst.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [SW-1:0] left, input logic [SW-1:0] right);
        t_frame frame;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        frame.left    = left;
        frame.right   = right;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        do @(posedge i_clk); while (!s_axis_tready);
        // request taken: predict with the register values now in force
        frame.left  = expand_channel(left);
        frame.right = expand_channel(right);
        pending_results.push_back(frame);
        @(negedge i_clk);
    endtask

    // Write one register with the pipeline empty; the block saturates values above unity
    task automatic write_reg(input t_cfg_reg idx, input logic [GAIN_BITS-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (value > UNIT_Q16) value = UNIT_Q16;
        if (idx == CFG_INPUT_GAIN) gain_q16 = value;
        else mix_q16 = value;
        @(negedge i_clk);
    endtask

    // Register value: zero, unity, above range, or anything in between
    function automatic logic [GAIN_BITS-1:0] pick_q16_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return UNIT_Q16;
            2:       return GAIN_BITS'($urandom_range(65537, 131071));
            default: return GAIN_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    // Sample value weighted toward the region the curve actually covers
    function automatic logic [SW-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return SW'($urandom_range(0, 2 << FRAC) - (1 << FRAC));
        else if (sel < 8)
            return SW'($urandom);
        else if (sel < 9)
            return SW'($urandom_range(0, 512) - 256);
        else
            return SW'((($urandom_range(0, 1) != 0) ? -(1 << FRAC) : (1 << FRAC))
                       + $urandom_range(0, 8) - 4);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unity gain, fully wet: zero, +/-1.0 and its neighbors, range limits, bit patterns
    task automatic test_unity_extremes();
        send_request('0, '0);
        send_request(ONE_Q20, -ONE_Q20);
        send_request(ONE_Q20 - 1, -(ONE_Q20 - 1));
        send_request(ONE_Q20 + 1, -(ONE_Q20 + 1));
        send_request(MAX_S, MIN_S);
        send_request(MIN_S, MAX_S);
        send_request(SW'(1), SW'(-1));
        send_request(SW'(1 << (FRAC - 1)), SW'(-(1 << (FRAC - 1))));
        send_request(SW'(24'h555555), SW'(24'hAAAAAA));
        send_request(SW'(24'hAAAAAA), SW'(24'h555555));
        send_request(SW'(1 << (FRAC - 3)), SW'(3 << (FRAC - 3)));
        send_request(SW'(12345), SW'(-777777));
    endtask

    // Register corners: zero gain, dry only, values above unity saturating
    task automatic test_register_extremes();
        write_reg(CFG_INPUT_GAIN, '0);
        send_request(MAX_S, MIN_S);
        send_request(ONE_Q20, SW'(-5));
        write_reg(CFG_INPUT_GAIN, '1);          // above range, acts as unity
        write_reg(CFG_WET_MIX, '0);
        send_request(MAX_S, MIN_S);
        send_request(SW'(24'h0F0F0F), SW'(-3));
        write_reg(CFG_INPUT_GAIN, GAIN_BITS'(32768));
        write_reg(CFG_WET_MIX, GAIN_BITS'(65537));
        send_request(ONE_Q20, -ONE_Q20);
        send_request(MAX_S, SW'(1 << (FRAC - 1)));
        write_reg(CFG_WET_MIX, GAIN_BITS'(32768));
        send_request(ONE_Q20, MIN_S);
        send_request(SW'(-1), SW'(1));
    endtask

    // Random frames over several random register settings, with idling on both sides
    task automatic test_random_settings();
        idle_on = 1'b1;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(CFG_INPUT_GAIN, pick_q16_setting());
            write_reg(CFG_WET_MIX, pick_q16_setting());
            // every third phase runs without idling for a back-to-back stretch
            idle_on = (ph % 3) != 2;
            for (int k = 0; k < PHASE_REQS; k++)
                send_request(pick_sample(), pick_sample());
        end
    endtask

    // Last stretch: no idling, unity gain and a random mix
    task automatic test_full_rate();
        idle_on = 1'b0;
        write_reg(CFG_INPUT_GAIN, UNIT_Q16);
        write_reg(CFG_WET_MIX, GAIN_BITS'($urandom_range(0, 65536)));
        for (int k = 0; k < CALM_REQS; k++)
            send_request(pick_sample(), pick_sample());
    endtask

    initial begin
        build_pow2_table();
        @(posedge i_rst_n);
        @(negedge i_clk);
        test_unity_extremes();
        test_register_extremes();
        test_random_settings();
        test_full_rate();
        // drop valid, drain the pipeline, then leave room for stray results
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[stereo_mu_law_expander] OK");
        else
            $display("[stereo_mu_law_expander] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/smle_pkg.sv
rtl/smle_ctrl.sv
rtl/smle_lane.sv
rtl/smle_merge.sv
rtl/stereo_mu_law_expander.sv
verif/tb.sv
